@@ src/mt64_pkg.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 shared definitions
// Sizes, constants, operation codes and the structs that travel between the
// sequencer, the state memory and the multiplier.
// ----------------------------------------------------------------------------
package mt64_pkg;

  localparam int STATE_WORDS   = 312;
  localparam int MIDDLE_OFFSET = 156;
  localparam int WORD_W        = 64;
  localparam int ADDR_W        = $clog2(STATE_WORDS);
  // The read index also holds the never-seeded mark one above the store size.
  localparam int IDX_W         = $clog2(STATE_WORDS + 2);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);
  localparam addr_t MID_ADDR  = addr_t'(MIDDLE_OFFSET);
  localparam idx_t  IDX_FULL  = idx_t'(STATE_WORDS);
  localparam idx_t  UNSEEDED  = idx_t'(STATE_WORDS + 1);

  localparam logic [1:0] OP_NEXT = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_KEY  = 2'd2;

  localparam word_t MUL_LIN      = 64'd6364136223846793005;
  localparam word_t MUL_KEY1     = 64'd3935559000370003845;
  localparam word_t MUL_KEY2     = 64'd2862933555777941757;
  localparam word_t TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam word_t UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam word_t LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam word_t TEMPER_D     = 64'h5555_5555_5555_5555;
  localparam word_t TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
  localparam word_t TEMPER_C     = 64'hFFF7_EEE0_0000_0000;
  localparam word_t SEED_DEFAULT = 64'd5489;
  localparam word_t SEED_BASE    = 64'd19650218;
  localparam word_t WORD0_FORCED = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  function automatic word_t fixed_key(input logic [1:0] j);
    word_t k;
    unique case (j)
      2'd0: k = 64'h12345;
      2'd1: k = 64'h23456;
      2'd2: k = 64'h34567;
      default: k = 64'h45678;
    endcase
    return k;
  endfunction

endpackage

@@ src/mt64_if.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 stream interfaces
// Request channel (operation and seed) and result channel (tempered word).
// ----------------------------------------------------------------------------
interface mt64_req_if;
  logic          valid;
  logic          ready;
  logic [1:0]    operation;
  mt64_pkg::word_t seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface mt64_word_if;
  logic            valid;
  logic            ready;
  mt64_pkg::word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

@@ src/mt64_ram.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 state memory
// One write port and two registered read ports over the 312-word store.
// ----------------------------------------------------------------------------
module mt64_ram (
  input  logic              clk,
  input  mt64_pkg::mem_wr_t wr,
  input  mt64_pkg::addr_t   rd_addr_a,
  input  mt64_pkg::addr_t   rd_addr_b,
  output mt64_pkg::word_t   rd_data_a,
  output mt64_pkg::word_t   rd_data_b
);

  mt64_pkg::word_t mem [0:mt64_pkg::STATE_WORDS-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ src/mt64_mul.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 multiplier
// Low 64 bits of a 64x64 product from three 32x32 partial products, one per
// cycle on a shared multiplier. The result is valid when done pulses.
// ----------------------------------------------------------------------------
module mt64_mul (
  input  logic               clk,
  input  logic               rst,
  input  mt64_pkg::mul_req_t req,
  output logic               done,
  output mt64_pkg::word_t    prod
);

  mt64_pkg::word_t a;
  mt64_pkg::word_t b;
  logic            busy;
  logic [1:0]      step;
  logic [31:0]     mx;
  logic [31:0]     my;
  logic [63:0]     pp;

  always_comb begin
    unique case (step)
      2'd0: begin
        mx = a[31:0];
        my = b[31:0];
      end
      2'd1: begin
        mx = a[31:0];
        my = b[63:32];
      end
      default: begin
        mx = a[63:32];
        my = b[31:0];
      end
    endcase
  end

  assign pp = mx * my;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Only the low half of each cross term lands inside the 64-bit result.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      if (step == 2'd0) begin
        prod <= pp;
      end else begin
        prod <= prod + {pp[31:0], 32'd0};
      end
    end
  end

endmodule

@@ src/mt64_seq.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 sequencer
// Walks the state memory for seeding, key mixing, twisting and word reads,
// driving the memory ports and the shared multiplier.
// ----------------------------------------------------------------------------
module mt64_seq (
  input  logic               clk,
  input  logic               rst,
  mt64_req_if.sink           req,
  output mt64_pkg::mem_wr_t  wr,
  output mt64_pkg::addr_t    rd_addr_a,
  output mt64_pkg::addr_t    rd_addr_b,
  input  mt64_pkg::word_t    rd_data_a,
  input  mt64_pkg::word_t    rd_data_b,
  output mt64_pkg::mul_req_t mul_req,
  input  logic               mul_done,
  input  mt64_pkg::word_t    mul_prod,
  input  logic               out_free,
  output logic               out_load,
  output mt64_pkg::word_t    out_raw
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_LIN_W0   = 14'b00000000000010,
    S_LIN_MUL  = 14'b00000000000100,
    S_LIN_WAIT = 14'b00000000001000,
    S_KEY_MUL  = 14'b00000000010000,
    S_KEY_WAIT = 14'b00000000100000,
    S_KEY_WRAP = 14'b00000001000000,
    S_KEY_NEXT = 14'b00000010000000,
    S_KEY_FIX  = 14'b00000100000000,
    S_TW_PRIME = 14'b00001000000000,
    S_TW_LOAD  = 14'b00010000000000,
    S_TW_RUN   = 14'b00100000000000,
    S_READ     = 14'b01000000000000,
    S_TEMPER   = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    G_WORD = 3'b001,
    G_SEED = 3'b010,
    G_KEY  = 3'b100
  } goal_t;

  state_t          state;
  goal_t           goal;
  mt64_pkg::idx_t  idx;
  mt64_pkg::word_t p;
  mt64_pkg::word_t cur;
  mt64_pkg::addr_t n;
  mt64_pkg::addr_t i;
  logic [1:0]      j;
  mt64_pkg::addr_t k;
  logic            phase2;
  mt64_pkg::addr_t addr_a;
  mt64_pkg::addr_t addr_b;

  mt64_pkg::word_t lin_val;
  mt64_pkg::word_t key_val;
  mt64_pkg::word_t mix;
  mt64_pkg::word_t y;
  mt64_pkg::word_t tw_val;

  assign req.ready = (state == S_IDLE);

  assign lin_val = mul_prod + mt64_pkg::word_t'(n);
  assign mix     = rd_data_a ^ mul_prod;
  assign key_val = phase2 ? (mix - mt64_pkg::word_t'(i))
                          : (mix + mt64_pkg::fixed_key(j) + mt64_pkg::word_t'(j));

  assign y      = (cur & mt64_pkg::UPPER_MASK) | (rd_data_a & mt64_pkg::LOWER_MASK);
  assign tw_val = rd_data_b ^ (y >> 1) ^ (y[0] ? mt64_pkg::TWIST_MATRIX : '0);

  assign mul_req.start = (state == S_LIN_MUL) || (state == S_KEY_MUL);
  assign mul_req.a     = p ^ (p >> 62);
  assign mul_req.b     = (state == S_LIN_MUL) ? mt64_pkg::MUL_LIN
                       : (phase2 ? mt64_pkg::MUL_KEY2 : mt64_pkg::MUL_KEY1);

  assign out_load  = (state == S_TEMPER) && out_free;
  assign out_raw   = rd_data_a;
  assign rd_addr_b = addr_b;

  always_comb begin
    unique case (state)
      S_KEY_MUL, S_KEY_WAIT: rd_addr_a = i;
      S_TW_PRIME:            rd_addr_a = '0;
      S_READ, S_TEMPER:      rd_addr_a = idx[mt64_pkg::ADDR_W-1:0];
      default:               rd_addr_a = addr_a;
    endcase
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = '0;
    wr.data = p;
    unique case (state)
      S_LIN_W0, S_KEY_WRAP: begin
        wr.en = 1'b1;
      end
      S_LIN_WAIT: begin
        wr.en   = mul_done;
        wr.addr = n;
        wr.data = lin_val;
      end
      S_KEY_WAIT: begin
        wr.en   = mul_done;
        wr.addr = i;
        wr.data = key_val;
      end
      S_KEY_FIX: begin
        wr.en   = 1'b1;
        wr.data = mt64_pkg::WORD0_FORCED;
      end
      S_TW_RUN: begin
        wr.en   = 1'b1;
        wr.addr = n;
        wr.data = tw_val;
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      goal  <= G_SEED;
      idx   <= mt64_pkg::UNSEEDED;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            priority case (req.operation)
              mt64_pkg::OP_NEXT: begin
                goal <= G_WORD;
                if (idx == mt64_pkg::UNSEEDED) begin
                  p     <= mt64_pkg::SEED_DEFAULT;
                  state <= S_LIN_W0;
                end else if (idx >= mt64_pkg::IDX_FULL) begin
                  state <= S_TW_PRIME;
                end else begin
                  state <= S_READ;
                end
              end
              mt64_pkg::OP_SEED: begin
                p     <= req.seed_value;
                goal  <= G_SEED;
                state <= S_LIN_W0;
              end
              mt64_pkg::OP_KEY: begin
                p     <= mt64_pkg::SEED_BASE;
                goal  <= G_KEY;
                state <= S_LIN_W0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LIN_W0: begin
          n     <= mt64_pkg::addr_t'(1);
          state <= S_LIN_MUL;
        end
        S_LIN_MUL: state <= S_LIN_WAIT;
        S_LIN_WAIT: begin
          if (mul_done) begin
            p <= lin_val;
            if (n == mt64_pkg::LAST_ADDR) begin
              idx <= mt64_pkg::IDX_FULL;
              unique case (goal)
                G_WORD: state <= S_TW_PRIME;
                G_KEY: begin
                  // Key mixing restarts from word 0, which holds the base seed.
                  p      <= mt64_pkg::SEED_BASE;
                  i      <= mt64_pkg::addr_t'(1);
                  j      <= 2'd0;
                  k      <= mt64_pkg::addr_t'(mt64_pkg::STATE_WORDS);
                  phase2 <= 1'b0;
                  state  <= S_KEY_MUL;
                end
                default: state <= S_IDLE;
              endcase
            end else begin
              n     <= n + mt64_pkg::addr_t'(1);
              state <= S_LIN_MUL;
            end
          end
        end
        S_KEY_MUL: state <= S_KEY_WAIT;
        S_KEY_WAIT: begin
          if (mul_done) begin
            p <= key_val;
            k <= k - mt64_pkg::addr_t'(1);
            if (!phase2) begin
              j <= j + 2'd1;
            end
            if (i == mt64_pkg::LAST_ADDR) begin
              state <= S_KEY_WRAP;
            end else begin
              i     <= i + mt64_pkg::addr_t'(1);
              state <= S_KEY_NEXT;
            end
          end
        end
        S_KEY_WRAP: begin
          // Word 0 takes a copy of the last word just written.
          i     <= mt64_pkg::addr_t'(1);
          state <= S_KEY_NEXT;
        end
        S_KEY_NEXT: begin
          if (k == '0) begin
            if (!phase2) begin
              phase2 <= 1'b1;
              k      <= mt64_pkg::LAST_ADDR;
              state  <= S_KEY_MUL;
            end else begin
              state <= S_KEY_FIX;
            end
          end else begin
            state <= S_KEY_MUL;
          end
        end
        S_KEY_FIX: begin
          idx   <= mt64_pkg::IDX_FULL;
          state <= S_IDLE;
        end
        S_TW_PRIME: begin
          addr_a <= mt64_pkg::addr_t'(1);
          addr_b <= mt64_pkg::MID_ADDR;
          state  <= S_TW_LOAD;
        end
        S_TW_LOAD, S_TW_RUN: begin
          // Reads run one word ahead of the write; the next word's old value
          // is kept as the current word for the following step.
          cur    <= rd_data_a;
          addr_a <= (addr_a == mt64_pkg::LAST_ADDR) ? '0 : addr_a + mt64_pkg::addr_t'(1);
          addr_b <= (addr_b == mt64_pkg::LAST_ADDR) ? '0 : addr_b + mt64_pkg::addr_t'(1);
          if (state == S_TW_LOAD) begin
            n     <= '0;
            state <= S_TW_RUN;
          end else if (n == mt64_pkg::LAST_ADDR) begin
            idx   <= '0;
            state <= S_READ;
          end else begin
            n <= n + mt64_pkg::addr_t'(1);
          end
        end
        S_READ: state <= S_TEMPER;
        S_TEMPER: begin
          if (out_free) begin
            idx   <= idx + mt64_pkg::idx_t'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/mersenne_twister_64_generator_top.sv @@
// ----------------------------------------------------------------------------
// MT19937-64 generator, top level
// Request channel in, tempered word channel out, state in one memory.
// ----------------------------------------------------------------------------
// Requests arrive on req: operation 0 asks for the next word, 1 reseeds from
// seed_value, 2 reseeds by the fixed key array, 3 does nothing. Only
// operation 0 makes a transfer on rsp, carrying random_word.
// One request is worked on at a time. A word from a seeded store is read
// in the read state and tempered into the output register from the temper
// state; plain reads are bound by the memory read and output stage.
// Every 312 words the store is twisted first, one word per cycle through
// the two read ports and the write port. Seeding from a value and by the
// key both work word by word on the shared multiplier. After reset the
// block is unseeded: the first word request seeds with 5489, then twists.
// The output register lets a new request be taken while a word waits on
// rsp; a word request stalls only when it reaches the output with the
// previous word still not taken.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator_top (
  input  logic         clk,
  input  logic         rst,
  mt64_req_if.sink     req,
  mt64_word_if.source  rsp
);

  mt64_pkg::mem_wr_t  wr;
  mt64_pkg::addr_t    rd_addr_a;
  mt64_pkg::addr_t    rd_addr_b;
  mt64_pkg::word_t    rd_data_a;
  mt64_pkg::word_t    rd_data_b;
  mt64_pkg::mul_req_t mul_req;
  logic               mul_done;
  mt64_pkg::word_t    mul_prod;
  logic               out_free;
  logic               out_load;
  mt64_pkg::word_t    out_raw;
  logic               out_valid;
  mt64_pkg::word_t    out_word;

  function automatic mt64_pkg::word_t temper(input mt64_pkg::word_t w);
    mt64_pkg::word_t x;
    x = w;
    x = x ^ ((x >> 29) & mt64_pkg::TEMPER_D);
    x = x ^ ((x << 17) & mt64_pkg::TEMPER_B);
    x = x ^ ((x << 37) & mt64_pkg::TEMPER_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

  mt64_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mt64_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  mt64_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .mul_req   (mul_req),
    .mul_done  (mul_done),
    .mul_prod  (mul_prod),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_raw   (out_raw)
  );

  assign out_free        = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= temper(out_raw);
    end
  end

endmodule

@@ dv/mersenne_twister_64_generator_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937-64 generator testbench
// Drives word requests, value seeds, key seeds and unused operations into the
// generator with bursty input and a stalling output. Every accepted seed or word
// request updates a local copy of the twister state, and each word that leaves the
// block is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator_top_test;

  typedef mt64_pkg::word_t word_t;

  localparam logic [1:0] OP_NOOP = 2'd3;

  localparam int       TWISTER_DEPTH = 312;
  localparam int       MID_STEP      = 156;
  localparam logic [8:0] NEVER_SEEDED = 9'd313;

  localparam word_t LCG_MULT      = 64'd6364136223846793005;
  localparam word_t KEY_MULT_A    = 64'd3935559000370003845;
  localparam word_t KEY_MULT_B    = 64'd2862933555777941757;
  localparam word_t TWIST_XOR     = 64'hB502_6F5A_A966_19E9;
  localparam word_t HI_MASK       = 64'hFFFF_FFFF_8000_0000;
  localparam word_t LO_MASK       = 64'h0000_0000_7FFF_FFFF;
  localparam word_t TEMPER_D_MASK = 64'h5555_5555_5555_5555;
  localparam word_t TEMPER_B_MASK = 64'h71D6_7FFF_EDA6_0000;
  localparam word_t TEMPER_C_MASK = 64'hFFF7_EEE0_0000_0000;
  localparam word_t DEFAULT_SEED  = 64'd5489;
  localparam word_t KEY_BASE_SEED = 64'd19650218;
  localparam word_t KEY_WORD0     = 64'h8000_0000_0000_0000;

  localparam int IDLE_LIMIT   = 30000;
  localparam int DRAIN_CYCLES = 6000;
  localparam int HOLD_CYCLES  = 400;

  logic clk;
  logic rst;

  mt64_req_if  req_if ();
  mt64_word_if rsp_if ();

  mersenne_twister_64_generator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Local copy of the generator state.
  word_t      twister [TWISTER_DEPTH];
  logic [8:0] read_pos;

  word_t expected_words [$];
  int    error_count;
  int    burst_left;
  int    idle_cycles;
  bit    long_hold_pending;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // State predictor
  // --------------------------------------------------------------------------
  function automatic word_t key_word(input int j);
    word_t k;
    case (j)
      0: k = 64'h12345;
      1: k = 64'h23456;
      2: k = 64'h34567;
      default: k = 64'h45678;
    endcase
    return k;
  endfunction

  function automatic void seed_from_value(input word_t s);
    word_t p;
    twister[0] = s;
    for (int n = 1; n < TWISTER_DEPTH; n++) begin
      p = twister[n-1];
      twister[n] = LCG_MULT * (p ^ (p >> 62)) + word_t'(n);
    end
    read_pos = 9'(TWISTER_DEPTH);
  endfunction

  function automatic void seed_from_key();
    word_t p;
    int    i;
    int    j;
    i = 1;
    j = 0;
    seed_from_value(KEY_BASE_SEED);
    for (int k = TWISTER_DEPTH; k > 0; k--) begin
      p = twister[i-1];
      twister[i] = (twister[i] ^ ((p ^ (p >> 62)) * KEY_MULT_A)) + key_word(j) + word_t'(j);
      i++;
      j++;
      if (i >= TWISTER_DEPTH) begin
        twister[0] = twister[TWISTER_DEPTH-1];
        i = 1;
      end
      if (j >= 4) j = 0;
    end
    for (int k = TWISTER_DEPTH - 1; k > 0; k--) begin
      p = twister[i-1];
      twister[i] = (twister[i] ^ ((p ^ (p >> 62)) * KEY_MULT_B)) - word_t'(i);
      i++;
      if (i >= TWISTER_DEPTH) begin
        twister[0] = twister[TWISTER_DEPTH-1];
        i = 1;
      end
    end
    twister[0] = KEY_WORD0;
    read_pos = 9'(TWISTER_DEPTH);
  endfunction

  // The update runs in place, so the last word already sees the new word 0.
  function automatic void twist_store();
    word_t y;
    word_t v;
    for (int n = 0; n < TWISTER_DEPTH; n++) begin
      y = (twister[n] & HI_MASK) | (twister[(n + 1) % TWISTER_DEPTH] & LO_MASK);
      v = twister[(n + MID_STEP) % TWISTER_DEPTH] ^ (y >> 1);
      if (y[0]) v = v ^ TWIST_XOR;
      twister[n] = v;
    end
    read_pos = '0;
  endfunction

  function automatic word_t draw_word();
    word_t x;
    if (read_pos >= 9'(TWISTER_DEPTH)) begin
      if (read_pos == NEVER_SEEDED) seed_from_value(DEFAULT_SEED);
      twist_store();
    end
    x = twister[read_pos];
    read_pos = read_pos + 9'd1;
    x = x ^ ((x >> 29) & TEMPER_D_MASK);
    x = x ^ ((x << 17) & TEMPER_B_MASK);
    x = x ^ ((x << 37) & TEMPER_C_MASK);
    x = x ^ (x >> 43);
    return x;
  endfunction

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] mismatch: %s: got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Results are checked before the request of the same edge is predicted, so
  // the order of the two within one edge is fixed.
  always @(posedge clk) begin : check_transfers
    word_t want;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no request waiting", rsp_if.random_word, '0);
        end else begin
          want = expected_words.pop_front();
          if (rsp_if.random_word !== want)
            report_mismatch("random_word", rsp_if.random_word, want);
        end
      end
      if (req_if.valid && req_if.ready) begin
        case (req_if.operation)
          mt64_pkg::OP_NEXT: expected_words.push_back(draw_word());
          mt64_pkg::OP_SEED: seed_from_value(req_if.seed_value);
          mt64_pkg::OP_KEY:  seed_from_key();
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("mersenne_twister_64_generator_top_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Word receiver: stall modes change after runs of random length; a long hold
  // can be requested to back the block up into its request port.
  // --------------------------------------------------------------------------
  initial begin : word_receiver
    int         mode;
    int         left;
    logic [7:0] mask;
    rsp_if.ready = 1'b0;
    left = 0;
    mode = 0;
    mask = '0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 96);
          mask = 8'($urandom);
        end
        left--;
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= mask[left % 8];
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request sender: bursts of random length separated by random gaps. Valid
  // stays high between requests of one burst.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] op, input word_t seed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.seed_value <= seed;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // The first words after reset come from the implicit default seed.
  task automatic test_unseeded_start();
    repeat (3) send_request(mt64_pkg::OP_NEXT, rand64());
  endtask

  task automatic test_unused_operation();
    send_request(OP_NOOP, rand64());
    send_request(mt64_pkg::OP_NEXT, '1);
  endtask

  task automatic test_seed_extremes();
    send_request(mt64_pkg::OP_SEED, '0);
    repeat (2) send_request(mt64_pkg::OP_NEXT, rand64());
    send_request(mt64_pkg::OP_SEED, '1);
    repeat (2) send_request(mt64_pkg::OP_NEXT, '0);
    send_request(mt64_pkg::OP_SEED, DEFAULT_SEED);
    send_request(mt64_pkg::OP_NEXT, rand64());
  endtask

  task automatic test_key_seeding();
    send_request(mt64_pkg::OP_KEY, rand64());
    repeat (2) send_request(mt64_pkg::OP_NEXT, rand64());
    send_request(mt64_pkg::OP_KEY, '1);
    send_request(mt64_pkg::OP_KEY, '0);
    send_request(mt64_pkg::OP_NEXT, rand64());
  endtask

  task automatic test_back_to_back_seeds();
    send_request(mt64_pkg::OP_SEED, rand64());
    send_request(mt64_pkg::OP_SEED, rand64());
    send_request(mt64_pkg::OP_NEXT, rand64());
  endtask

  task automatic test_output_backpressure();
    long_hold_pending = 1'b1;
    repeat (24) send_request(mt64_pkg::OP_NEXT, rand64());
  endtask

  // Mostly seeded runs of word requests, some long enough to cross a twist
  // inside the store, with stray unused operations as noise.
  task automatic test_random_stream(input int target);
    int    sent;
    int    pick;
    int    run;
    word_t seed;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        seed = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 15)) : rand64();
        send_request(mt64_pkg::OP_SEED, seed);
        sent++;
      end else if (pick < 67) begin
        send_request(mt64_pkg::OP_KEY, rand64());
        sent++;
      end
      run = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(250, 700);
      if (run > target - sent) run = target - sent;
      for (int n = 0; n < run; n++) begin
        if ($urandom_range(0, 49) == 0) send_request(OP_NOOP, rand64());
        send_request(mt64_pkg::OP_NEXT, rand64());
        sent++;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    req_if.valid      = 1'b0;
    req_if.operation  = mt64_pkg::OP_NEXT;
    req_if.seed_value = '0;
    error_count       = 0;
    burst_left        = 0;
    long_hold_pending = 1'b0;
    read_pos          = NEVER_SEEDED;
    for (int n = 0; n < TWISTER_DEPTH; n++) twister[n] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unseeded_start();
    test_unused_operation();
    test_seed_extremes();
    test_key_seeding();
    test_back_to_back_seeds();
    test_output_backpressure();
    test_random_stream(1800);

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // A trailing seed may still be running; any stray word shows up here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("mersenne_twister_64_generator_top_test: PASS");
    end else begin
      $display("mersenne_twister_64_generator_top_test: FAIL");
    end
    $finish;
  end

endmodule
